[rtl/core/segment_surface_shadow_test_defines.svh]
// ----------------------------------------------------------------------------
// Shadow test assertion macros
// Shared property wrappers, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_SURFACE_SHADOW_TEST_DEFINES_SVH
`define SEGMENT_SURFACE_SHADOW_TEST_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SST_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SST_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/sst_pkg.sv]
// ----------------------------------------------------------------------------
// Shadow test package
// Field widths, operation and register codes, engine handshake structs.
// ----------------------------------------------------------------------------
package sst_pkg;

   localparam int OP_BITS        = 2;
   localparam int ELEM_IDX_BITS  = 10;
   localparam int CORNER_BITS    = 2;
   localparam int POINT_ID_BITS  = 20;
   localparam int CSR_INDEX_BITS = 3;
   localparam int COUNT_BITS     = 11;

   typedef enum logic [OP_BITS-1:0] {
      OP_CORNER = 2'd0,
      OP_NORMAL = 2'd1,
      OP_NODE   = 2'd2,
      OP_QUERY  = 2'd3
   } sst_op_type;

   localparam logic [CSR_INDEX_BITS-1:0] REG_CHARGE_X   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CHARGE_Y   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CHARGE_Z   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TRI_MODE   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ELEM_COUNT = 3'd4;

   typedef struct packed {
      logic start;
      logic ack;
   } sst_eng_ctl_type;

   typedef struct packed {
      logic done;
      logic hit;
   } sst_eng_sts_type;

endpackage

[rtl/core/sst_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/sst_engine.sv]
// ----------------------------------------------------------------------------
// Shadow test element engine
// Walks the element table for one query point; one shared multiplier and
// accumulator evaluate the plane ratio and the exact box compares.
// ----------------------------------------------------------------------------
module sst_engine import sst_pkg::*; #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int COORD_BITS   = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  sst_eng_ctl_type                ctl,
   output sst_eng_sts_type                sts,
   input  logic signed [COORD_BITS-1:0]   charge_x,
   input  logic signed [COORD_BITS-1:0]   charge_y,
   input  logic signed [COORD_BITS-1:0]   charge_z,
   input  logic                           triangle_mode,
   input  logic [COUNT_BITS-1:0]          element_count,
   input  logic signed [COORD_BITS-1:0]   pt_x,
   input  logic signed [COORD_BITS-1:0]   pt_y,
   input  logic signed [COORD_BITS-1:0]   pt_z,
   output logic [(MAX_ELEMENTS > 1 ? $clog2(MAX_ELEMENTS) : 1)-1:0] nrm_raddr,
   input  logic [3*COORD_BITS-1:0]        nrm_rdata,
   output logic [(MAX_ELEMENTS > 1 ? $clog2(MAX_ELEMENTS) : 1)+1:0] cnr_raddr,
   input  logic [3*COORD_BITS-1:0]        cnr_rdata
);

   `include "segment_surface_shadow_test_defines.svh"

   localparam int CW   = COORD_BITS;
   localparam int DW   = CW + 1;
   localparam int MW   = CW + 2;
   localparam int PW   = 2 * MW;
   localparam int NW   = 2 * CW + 3;
   localparam int XW   = 3 * CW + 4;
   localparam int RW   = NW + 7;
   localparam int EAW  = MAX_ELEMENTS > 1 ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CNTW = $clog2(MAX_ELEMENTS + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_FETCH, ST_LATCH, ST_CORN, ST_PREP, ST_ISS, ST_WAIT,
      ST_CHK, ST_NORM, ST_RATIO, ST_MISS, ST_DONE
   } state_type;

   state_type             state_ff;
   logic [CNTW-1:0]       e_ff, cnt_ff, cnt_in;
   logic [1:0]            kk_ff, q_ff, last_k, last_q;
   logic [2:0]            g_ff, gb;
   logic [1:0]            ax;
   logic                  kind;
   logic                  hit_ff, last_e;
   logic signed [DW-1:0]  d_ff [3];
   logic signed [DW-1:0]  w_ff [3];
   logic signed [DW-1:0]  lod_ff [3];
   logic signed [DW-1:0]  hid_ff [3];
   logic signed [CW-1:0]  n_ff [3];
   logic signed [CW-1:0]  lo_ff [3];
   logic signed [CW-1:0]  hi_ff [3];
   logic signed [CW-1:0]  cx [3];
   logic signed [CW-1:0]  nx [3];
   logic signed [CW-1:0]  cc [3];
   logic signed [CW-1:0]  pp [3];
   logic signed [NW-1:0]  num_ff, den_ff;
   logic signed [MW-1:0]  ma, mb, num_l, num_h, den_l, den_h;
   logic signed [PW-1:0]  prod_ff;
   logic                  pv_ff, clr_ff, sh_ff, neg_ff;
   logic signed [XW-1:0]  acc_ff, acc_in, term;
   logic signed [RW-1:0]  nr, dr, n100, d99;

   assign cc[0] = charge_x;
   assign cc[1] = charge_y;
   assign cc[2] = charge_z;
   assign pp[0] = pt_x;
   assign pp[1] = pt_y;
   assign pp[2] = pt_z;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         cx[a] = $signed(cnr_rdata[a*CW +: CW]);
         nx[a] = $signed(nrm_rdata[a*CW +: CW]);
      end
   end

   // element count saturates at the table size
   assign cnt_in = (32'(element_count) > 32'(MAX_ELEMENTS)) ? CNTW'(MAX_ELEMENTS)
                                                          : CNTW'(element_count);
   assign last_e = (e_ff + CNTW'(1)) == cnt_ff;
   assign last_k = triangle_mode ? 2'd2 : 2'd3;
   assign last_q = (g_ff < 3'd2) ? 2'd2 : 2'd3;

   assign nrm_raddr = e_ff[EAW-1:0];
   assign cnr_raddr = {e_ff[EAW-1:0], (state_ff == ST_FETCH) ? 2'd0 : kk_ff + 2'd1};

   // split operands: low part unsigned, high part signed
   assign num_l = $signed({1'b0, num_ff[CW:0]});
   assign num_h = $signed(num_ff[NW-1:CW+1]);
   assign den_l = $signed({1'b0, den_ff[CW:0]});
   assign den_h = $signed(den_ff[NW-1:CW+1]);

   assign gb   = g_ff - 3'd2;
   assign ax   = gb[2:1];
   assign kind = gb[0];

   // group 0: den, group 1: num, groups 2..7: (lo-c)*den - num*d and
   // num*d - (hi-c)*den per axis, each as four partial products
   always_comb begin
      ma = '0;
      mb = '0;
      if (g_ff == 3'd0) begin
         ma = MW'(n_ff[q_ff]);
         mb = MW'(d_ff[q_ff]);
      end else if (g_ff == 3'd1) begin
         ma = MW'(n_ff[q_ff]);
         mb = MW'(w_ff[q_ff]);
      end else if (kind ^ q_ff[1]) begin
         ma = MW'(d_ff[ax]);
         mb = q_ff[0] ? num_h : num_l;
      end else begin
         ma = kind ? MW'(hid_ff[ax]) : MW'(lod_ff[ax]);
         mb = q_ff[0] ? den_h : den_l;
      end
   end

   always_comb begin
      term = XW'(prod_ff);
      if (sh_ff) begin
         term = term <<< (CW + 1);
      end
      acc_in = (clr_ff ? XW'(0) : acc_ff) + (neg_ff ? -term : term);
   end

   assign nr   = RW'(num_ff);
   assign dr   = RW'(den_ff);
   assign n100 = (nr <<< 6) + (nr <<< 5) + (nr <<< 2);
   assign d99  = (dr <<< 6) + (dr <<< 5) + (dr <<< 1) + dr;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pv_ff    <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         // product issued in ST_ISS is registered in prod_ff, then added into acc_ff
         pv_ff <= (state_ff == ST_ISS);
         if (pv_ff) begin
            acc_ff <= acc_in;
         end
         case (state_ff)
            ST_IDLE: begin
               if (ctl.start) begin
                  for (int a = 0; a < 3; a++) begin
                     d_ff[a] <= DW'(pp[a]) - DW'(cc[a]);
                  end
                  cnt_ff   <= cnt_in;
                  e_ff     <= '0;
                  hit_ff   <= 1'b0;
                  state_ff <= (cnt_in == '0) ? ST_DONE : ST_FETCH;
               end
            end
            ST_FETCH: begin
               kk_ff    <= 2'd0;
               state_ff <= ST_LATCH;
            end
            ST_LATCH: begin
               for (int a = 0; a < 3; a++) begin
                  n_ff[a]  <= nx[a];
                  w_ff[a]  <= DW'(cx[a]) - DW'(cc[a]);
                  lo_ff[a] <= cx[a];
                  hi_ff[a] <= cx[a];
               end
               kk_ff    <= 2'd1;
               state_ff <= ST_CORN;
            end
            ST_CORN: begin
               for (int a = 0; a < 3; a++) begin
                  if (cx[a] < lo_ff[a]) lo_ff[a] <= cx[a];
                  if (cx[a] > hi_ff[a]) hi_ff[a] <= cx[a];
               end
               if (kk_ff == last_k) begin
                  state_ff <= ST_PREP;
               end else begin
                  kk_ff <= kk_ff + 2'd1;
               end
            end
            ST_PREP: begin
               for (int a = 0; a < 3; a++) begin
                  lod_ff[a] <= DW'(lo_ff[a]) - DW'(cc[a]);
                  hid_ff[a] <= DW'(hi_ff[a]) - DW'(cc[a]);
               end
               g_ff     <= 3'd0;
               q_ff     <= 2'd0;
               state_ff <= ST_ISS;
            end
            ST_ISS: begin
               prod_ff <= ma * mb;
               clr_ff  <= (q_ff == 2'd0);
               sh_ff   <= (g_ff >= 3'd2) && q_ff[0];
               neg_ff  <= (g_ff >= 3'd2) && q_ff[1];
               if (q_ff == last_q) begin
                  state_ff <= ST_WAIT;
               end else begin
                  q_ff <= q_ff + 2'd1;
               end
            end
            ST_WAIT: begin
               state_ff <= ST_CHK;
            end
            ST_CHK: begin
               if (g_ff == 3'd0) begin
                  den_ff   <= acc_ff[NW-1:0];
                  g_ff     <= 3'd1;
                  q_ff     <= 2'd0;
                  state_ff <= ST_ISS;
               end else if (g_ff == 3'd1) begin
                  num_ff   <= acc_ff[NW-1:0];
                  state_ff <= ST_NORM;
               end else if (acc_ff > XW'(0)) begin
                  state_ff <= ST_MISS;
               end else if (g_ff == 3'd7) begin
                  hit_ff   <= 1'b1;
                  state_ff <= ST_DONE;
               end else begin
                  g_ff     <= g_ff + 3'd1;
                  q_ff     <= 2'd0;
                  state_ff <= ST_ISS;
               end
            end
            ST_NORM: begin
               if (den_ff == '0) begin
                  state_ff <= ST_MISS;
               end else begin
                  if (den_ff < NW'(0)) begin
                     den_ff <= -den_ff;
                     num_ff <= -num_ff;
                  end
                  state_ff <= ST_RATIO;
               end
            end
            ST_RATIO: begin
               if (num_ff < NW'(0) || n100 >= d99) begin
                  state_ff <= ST_MISS;
               end else begin
                  g_ff     <= 3'd2;
                  q_ff     <= 2'd0;
                  state_ff <= ST_ISS;
               end
            end
            ST_MISS: begin
               if (last_e) begin
                  state_ff <= ST_DONE;
               end else begin
                  e_ff     <= e_ff + CNTW'(1);
                  state_ff <= ST_FETCH;
               end
            end
            ST_DONE: begin
               if (ctl.ack) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign sts.done = (state_ff == ST_DONE);
   assign sts.hit  = hit_ff;

   `SST_ASSERT_NOW(a_fetch_in_range, state_ff == ST_FETCH, e_ff < cnt_ff,
      "element fetch beyond element count")
   `SST_ASSERT_NOW(a_chk_settled, state_ff == ST_CHK, !pv_ff,
      "accumulator checked with product in flight")

endmodule

[rtl/core/segment_surface_shadow_test.sv]
// ----------------------------------------------------------------------------
// Segment to surface shadow test
// Loads element corners, normals and a structural y range, then answers
// point queries with a prefilter flag and an element hit flag.
// ----------------------------------------------------------------------------
// Completion: loads and structural nodes complete at acceptance. A query that
//   fails the prefilter (or meets element_count 0) waits in busy_ff until
//   the output register is free; a passing query also waits for its walk.
// Walk: a passing query walks elements in order through one shared
//   multiplier, reading three corners in triangle mode, else four; an element
//   ends at a zero denominator or a failed ratio test, else runs the box
//   test, and the walk stops at the first hit.
// Reset: synchronous; configuration registers to 0, y range empty. Element
//   stores are not cleared and hold whatever was loaded.
module segment_surface_shadow_test import sst_pkg::*; #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int COORD_BITS   = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   // request transactions
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [OP_BITS-1:0]            req_op,
   input  logic [ELEM_IDX_BITS-1:0]      req_elem_index,
   input  logic [CORNER_BITS-1:0]        req_corner,
   input  logic signed [COORD_BITS-1:0]  req_coord_x,
   input  logic signed [COORD_BITS-1:0]  req_coord_y,
   input  logic signed [COORD_BITS-1:0]  req_coord_z,
   input  logic [POINT_ID_BITS-1:0]      req_point_id,
   // response transactions
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [POINT_ID_BITS-1:0]      rsp_out_point_id,
   output logic                          rsp_in_box,
   output logic                          rsp_hit,
   // register writes
   input  logic                          csr_we,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [COORD_BITS-1:0]         csr_wdata
);

   `include "segment_surface_shadow_test_defines.svh"

   localparam int CW  = COORD_BITS;
   localparam int EAW = MAX_ELEMENTS > 1 ? $clog2(MAX_ELEMENTS) : 1;

   // configuration
   logic signed [CW-1:0]   charge_x_ff, charge_y_ff, charge_z_ff;
   logic                   tri_mode_ff;
   logic [COUNT_BITS-1:0]  elem_count_ff;

   // structural y range, empty after reset
   logic signed [CW-1:0]   y_low_ff, y_high_ff;

   // transaction control
   logic                   busy_ff, pass_ff;
   logic [POINT_ID_BITS-1:0] id_ff;
   logic                   rsp_valid_ff, rsp_in_box_ff, rsp_hit_ff;
   logic [POINT_ID_BITS-1:0] rsp_id_ff;
   logic signed [CW-1:0]   qx_ff, qy_ff, qz_ff;

   logic                   req_accept, is_query, pass, idx_ok, out_free;
   logic                   res_ready, finish;
   logic [31:0]            idx_ext;
   logic [EAW-1:0]         eidx;

   sst_eng_ctl_type        eng_ctl;
   sst_eng_sts_type        eng_sts;

   logic                   cnr_we, nrm_we;
   logic [EAW-1:0]         nrm_raddr;
   logic [EAW+1:0]         cnr_raddr;
   logic [3*CW-1:0]        row_wdata, nrm_rdata, cnr_rdata;

   // one item at a time; loads complete on acceptance
   assign req_stall  = busy_ff;
   assign req_accept = req_valid && !req_stall;
   assign is_query   = (req_op == OP_QUERY);

   // prefilter: far side of z = 0 from the charge and inside the y range
   always_comb begin
      pass = (req_coord_y >= y_low_ff) && (req_coord_y <= y_high_ff);
      if (charge_z_ff > CW'(0)) begin
         pass = pass && (req_coord_z <= CW'(0));
      end else begin
         pass = pass && (req_coord_z >= CW'(0));
      end
   end

   // loads beyond the table are dropped
   assign idx_ext   = 32'(req_elem_index);
   assign idx_ok    = idx_ext < 32'(MAX_ELEMENTS);
   assign eidx      = idx_ext[EAW-1:0];
   assign row_wdata = {req_coord_z, req_coord_y, req_coord_x};
   assign cnr_we    = req_accept && (req_op == OP_CORNER) && idx_ok;
   assign nrm_we    = req_accept && (req_op == OP_NORMAL) && idx_ok;

   // result leaves through the output register; a waiting result does not
   // block the next finish once it is being taken
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign res_ready = busy_ff && (!pass_ff || eng_sts.done);
   assign finish    = res_ready && out_free;

   assign eng_ctl.start = req_accept && is_query && pass;
   assign eng_ctl.ack   = finish && pass_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         charge_x_ff   <= '0;
         charge_y_ff   <= '0;
         charge_z_ff   <= '0;
         tri_mode_ff   <= 1'b0;
         elem_count_ff <= '0;
         y_low_ff      <= $signed({1'b0, {(CW-1){1'b1}}});
         y_high_ff     <= $signed({1'b1, {(CW-1){1'b0}}});
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_CHARGE_X:   charge_x_ff   <= $signed(csr_wdata);
               REG_CHARGE_Y:   charge_y_ff   <= $signed(csr_wdata);
               REG_CHARGE_Z:   charge_z_ff   <= $signed(csr_wdata);
               REG_TRI_MODE:   tri_mode_ff   <= csr_wdata[0];
               REG_ELEM_COUNT: elem_count_ff <= csr_wdata[COUNT_BITS-1:0];
               default: ;
            endcase
         end
         if (req_accept && (req_op == OP_NODE)) begin
            if (req_coord_y < y_low_ff)  y_low_ff  <= req_coord_y;
            if (req_coord_y > y_high_ff) y_high_ff <= req_coord_y;
         end
         if (req_accept && is_query) begin
            busy_ff <= 1'b1;
            pass_ff <= pass;
            id_ff   <= req_point_id;
            qx_ff   <= req_coord_x;
            qy_ff   <= req_coord_y;
            qz_ff   <= req_coord_z;
         end else if (finish) begin
            busy_ff <= 1'b0;
         end
         if (finish) begin
            rsp_valid_ff  <= 1'b1;
            rsp_id_ff     <= id_ff;
            rsp_in_box_ff <= pass_ff;
            rsp_hit_ff    <= pass_ff && eng_sts.hit;
         end else if (!rsp_stall) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_point_id = rsp_id_ff;
   assign rsp_in_box       = rsp_in_box_ff;
   assign rsp_hit          = rsp_hit_ff;

   // element stores: one row per corner and per normal, x in the low bits
   sst_ram #(
      .WIDTH (3 * CW),
      .DEPTH ((1 << EAW) * 4)
   ) u_cnr_ram (
      .clock (clock),
      .we    (cnr_we),
      .waddr ({eidx, req_corner}),
      .wdata (row_wdata),
      .raddr (cnr_raddr),
      .rdata (cnr_rdata)
   );

   sst_ram #(
      .WIDTH (3 * CW),
      .DEPTH (1 << EAW)
   ) u_nrm_ram (
      .clock (clock),
      .we    (nrm_we),
      .waddr (eidx),
      .wdata (row_wdata),
      .raddr (nrm_raddr),
      .rdata (nrm_rdata)
   );

   sst_engine #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .COORD_BITS   (COORD_BITS)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .ctl           (eng_ctl),
      .sts           (eng_sts),
      .charge_x      (charge_x_ff),
      .charge_y      (charge_y_ff),
      .charge_z      (charge_z_ff),
      .triangle_mode (tri_mode_ff),
      .element_count (elem_count_ff),
      .pt_x          (req_coord_x),
      .pt_y          (req_coord_y),
      .pt_z          (req_coord_z),
      .nrm_raddr     (nrm_raddr),
      .nrm_rdata     (nrm_rdata),
      .cnr_raddr     (cnr_raddr),
      .cnr_rdata     (cnr_rdata)
   );

   // query point copy kept for the busy period
   `SST_ASSERT_NOW(a_stable_point, busy_ff && $past(busy_ff),
      qx_ff == $past(qx_ff) && qy_ff == $past(qy_ff) && qz_ff == $past(qz_ff),
      "query point changed while busy")
   `SST_ASSERT_NEXT(a_query_busy, req_accept && is_query, busy_ff,
      "query transaction did not start work")
   `SST_ASSERT_NOW(a_done_owned, eng_sts.done, busy_ff && pass_ff,
      "engine finished without a passing query")
   `SST_ASSERT_NOW(a_hit_in_box, rsp_valid_ff && rsp_hit_ff, rsp_in_box_ff,
      "hit reported for a point outside the prefilter")

endmodule
